### rtl/core/ccvol_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccvol_pkg
// Shared widths, register indexes and arithmetic constants of the
// close-to-close volatility block.
// ----------------------------------------------------------------------------
package ccvol_pkg;

   localparam int PRICE_W   = 48;   // Q32.16 close
   localparam int VOL_W     = 32;   // Q16.16 result
   localparam int WL_W      = 9;
   localparam int SCALE_W   = 24;   // Q8.16
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANNUAL_SCALE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEFAULT_VOLATILITY = 2'd2;

   localparam logic [WL_W-1:0]    WINDOW_LENGTH_RST      = 9'd30;
   localparam logic [SCALE_W-1:0] ANNUAL_SCALE_RST       = 24'd1040352;
   localparam logic [VOL_W-1:0]   DEFAULT_VOLATILITY_RST = 32'd13107;

   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

   // log2 result: 7-bit signed exponent, 32 fraction bits
   localparam int LOG_W  = 39;
   localparam int RET_W  = 40;
   localparam int SQ_W   = 49;   // one squared deviation, Q32
   localparam int VQ_W   = 49;   // variance after the divide
   localparam int SI     = 41;   // square root result bits
   localparam int SQC_W  = 6;
   localparam int LN_W   = 42;   // sd * ln2
   localparam int SPL_W  = 24;   // low split of sd_ln for the scale multiply

endpackage : ccvol_pkg
`default_nettype wire

### rtl/core/ccvol_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccvol_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module ccvol_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule : ccvol_ram
`default_nettype wire

### rtl/core/close_to_close_volatility.sv
`default_nettype none
// ----------------------------------------------------------------------------
// close_to_close_volatility
// Annualized close-to-close volatility over a ring of closing prices.
// ----------------------------------------------------------------------------
// Usage:
//   Input words (req_close_price, req_last_candle) are taken on a clock edge
//   with start high and busy low. A word without last_candle is written to
//   the close ring in that same cycle; busy stays low.
//   A word with last_candle starts the compute pass over the newest
//   n = min(fill count, window_length) closes; busy is high until the
//   result word appears on rsp_* with rsp_strobe for exactly one cycle.
//   There is no back-pressure on the result side.
//   Steps of a last word (n >= 2, m returns formed): the log pass (normalize
//     shifts and 32 squarings per close on one 32x32 multiplier), the
//     deviation pass over the m returns, two restoring divides, 41 square
//     root steps, then the ln2 and scale multiplies and the output.
//   With n < 2 the default word is issued from S_START; with no return
//   formed it is issued at the end of the log pass.
//   The ring and the return store are RAMs with one read port each; the
//   iterative log2 squaring and bit-serial divide/root set the pass length.
//   csr_* writes are registered and must only occur while idle.
//   Reset clears ring head, fill count, state and strobe and sets the csr
//   registers to defaults; ring contents are undefined, never read unwritten.
// ----------------------------------------------------------------------------
module close_to_close_volatility #(
   parameter int MAX_WINDOW = 256
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [ccvol_pkg::PRICE_W-1:0]      req_close_price,
   input  wire logic                               req_last_candle,
   output logic                                    rsp_strobe,
   output logic      [ccvol_pkg::VOL_W-1:0]        rsp_volatility,
   output logic                                    rsp_used_default,
   input  wire logic                               csr_wr_en,
   input  wire logic [ccvol_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ccvol_pkg::CSR_W-1:0]        csr_wdata
);

   import ccvol_pkg::*;

   localparam int AW    = $clog2(MAX_WINDOW);
   localparam int CW    = $clog2(MAX_WINDOW + 1);
   localparam int NW    = (CW > WL_W) ? CW : WL_W;
   localparam int SUM_W = RET_W + CW;
   localparam int DW    = SQ_W + CW;          // divider dividend width
   localparam int DCW   = $clog2(DW);

   typedef enum logic [17:0] {
      S_IDLE  = 18'h00001,
      S_START = 18'h00002,
      S_RD    = 18'h00004,
      S_LOAD  = 18'h00008,
      S_NORM  = 18'h00010,
      S_SQR   = 18'h00020,
      S_RET   = 18'h00040,
      S_MDIV  = 18'h00080,
      S_MEAN  = 18'h00100,
      S_P2RD  = 18'h00200,
      S_P2D   = 18'h00400,
      S_P2SQ  = 18'h00800,
      S_VDIV  = 18'h01000,
      S_SQRT  = 18'h02000,
      S_LN    = 18'h04000,
      S_LNADD = 18'h08000,
      S_SCL   = 18'h10000,
      S_OUT   = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   // config
   logic [WL_W-1:0]    window_length_ff;
   logic [SCALE_W-1:0] annual_scale_ff;
   logic [VOL_W-1:0]   default_volatility_ff;

   // ring bookkeeping
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] fill_ff, fill_in, fill_inc;
   logic [CW-1:0] n_ff, n_in;
   logic [AW-1:0] base_ff, base_in;
   logic [NW-1:0] fill_x, wl_x;
   logic [AW+1:0] hn_x, nb_x, base_x;
   logic          accept;

   // log pass
   logic [AW-1:0]        rd_addr_ff, rd_addr_in, rd_addr_nx;
   logic [CW-1:0]        k_ff, k_in;
   logic [CW-1:0]        m_ff, m_in;
   logic [PRICE_W-1:0]   x_ff, x_in;
   logic                 cur_zero_ff, cur_zero_in;
   logic                 prev_nz_ff, prev_nz_in;
   logic [5:0]           p_ff, p_in;
   logic [31:0]          y_ff, y_in;
   logic [31:0]          f_ff, f_in;
   logic [4:0]           it_ff, it_in;
   logic [63:0]          y_sq;
   logic [32:0]          y_t;
   logic [6:0]           expo;
   logic signed [LOG_W-1:0] log_cur, log_prev_ff, log_prev_in;
   logic signed [RET_W-1:0] ret_val;
   logic                 wrote;
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic [SUM_W-1:0]     sum_mag;

   // divider
   logic [DW-1:0]  dv_quo_ff, dv_quo_in, dv_quo_nx;
   logic [CW-1:0]  dv_rem_ff, dv_rem_in, dv_rem_nx;
   logic [DCW-1:0] dv_cnt_ff, dv_cnt_in;
   logic [CW:0]    dv_r2, dv_diff;
   logic           dv_ge;
   logic           neg_ff, neg_in;

   // deviation pass
   logic signed [RET_W-1:0] mean_ff, mean_in;
   logic [CW-1:0]           j_ff, j_in;
   logic signed [RET_W:0]   dev;
   logic [RET_W-1:0]        a_ff, a_in;
   logic [SQ_W-1:0]         sq_val;
   logic [DW-1:0]           var_ff, var_in;
   logic [RET_W-1:0]        ret_rd;

   // root, ln2, scale
   logic [2*SI-1:0] sv_ff, sv_in;
   logic [SI-1:0]   s_ff, s_in;
   logic [SI+1:0]   rem_ff, rem_in;
   logic [SQC_W-1:0] sq_cnt_ff, sq_cnt_in;
   logic [SI+3:0]   rem2, trial;
   logic [40:0]     m1_ff, m1_in;
   logic [31:0]     m2_ff, m2_in;
   logic [63:0]     m2_full;
   logic [LN_W-1:0] sdln_ff, sdln_in;
   logic [SPL_W+SCALE_W-1:0] plo_ff, plo_in;
   logic [LN_W-1:0] phi_ff, phi_in;
   logic [LN_W+SPL_W-1:0] total;

   // result word
   logic             rsp_strobe_ff, rsp_strobe_in;
   logic [VOL_W-1:0] rsp_vol_ff, rsp_vol_in;
   logic             rsp_def_ff, rsp_def_in;

   // memories
   logic [PRICE_W-1:0] ring_rdata;
   logic               ring_rd_en;
   logic               ret_we, ret_rd_en;
   logic [RET_W-1:0]   ret_wdata;
   logic [AW-1:0]      ret_rd_addr;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_volatility   = rsp_vol_ff;
   assign rsp_used_default = rsp_def_ff;

   ccvol_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_WINDOW)) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (head_ff),
      .wr_data (req_close_price),
      .rd_en   (ring_rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (ring_rdata)
   );

   ccvol_ram #(.WIDTH(RET_W), .DEPTH(MAX_WINDOW)) u_rets (
      .clock   (clock),
      .wr_en   (ret_we),
      .wr_addr (m_ff[AW-1:0]),
      .wr_data (ret_wdata),
      .rd_en   (ret_rd_en),
      .rd_addr (ret_rd_addr),
      .rd_data (ret_rd)
   );

   // ---- config port ------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff      <= WINDOW_LENGTH_RST;
         annual_scale_ff       <= ANNUAL_SCALE_RST;
         default_volatility_ff <= DEFAULT_VOLATILITY_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WINDOW_LENGTH:      window_length_ff      <= csr_wdata[WL_W-1:0];
            CSR_ANNUAL_SCALE:       annual_scale_ff       <= csr_wdata[SCALE_W-1:0];
            CSR_DEFAULT_VOLATILITY: default_volatility_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- ring head, fill count and window base on an accepted word -------
   always_comb begin
      head_in  = (head_ff == AW'(MAX_WINDOW - 1)) ? '0 : head_ff + 1'b1;
      fill_inc = (fill_ff == CW'(MAX_WINDOW)) ? fill_ff : fill_ff + 1'b1;
      fill_x   = NW'(fill_inc);
      wl_x     = NW'(window_length_ff);
      n_in     = (fill_x < wl_x) ? fill_inc : CW'(window_length_ff);
      hn_x     = (AW+2)'(head_in);
      nb_x     = (AW+2)'(n_in);
      base_x   = (hn_x >= nb_x) ? hn_x - nb_x : hn_x + (AW+2)'(MAX_WINDOW) - nb_x;
      base_in  = base_x[AW-1:0];
      fill_in  = req_last_candle ? '0 : fill_inc;
   end

   // ---- shared datapath pieces ------------------------------------------
   always_comb begin
      rd_addr_nx = (rd_addr_ff == AW'(MAX_WINDOW - 1)) ? '0 : rd_addr_ff + 1'b1;

      // one squaring step of the log2 fraction
      y_sq = 64'(y_ff) * 64'(y_ff);
      y_t  = y_sq[63:31];

      expo    = {1'b0, p_ff} - 7'd16;
      log_cur = {expo, f_ff};
      ret_val = RET_W'(log_cur) - RET_W'(log_prev_ff);
      wrote   = (k_ff != '0) && prev_nz_ff;
      sum_add = wrote ? SUM_W'(ret_val) : '0;
      sum_in  = sum_ff + sum_add;
      sum_mag = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);

      // restoring divide step, divisor is the return count
      dv_r2     = {dv_rem_ff, dv_quo_ff[DW-1]};
      dv_ge     = dv_r2 >= {1'b0, m_ff};
      dv_diff   = dv_r2 - {1'b0, m_ff};
      dv_rem_nx = dv_ge ? dv_diff[CW-1:0] : dv_r2[CW-1:0];
      dv_quo_nx = {dv_quo_ff[DW-2:0], dv_ge};

      dev    = (RET_W+1)'($signed(ret_rd)) - (RET_W+1)'(mean_ff);
      a_in   = dev[RET_W] ? RET_W'(-dev) : RET_W'(dev);
      // (a*a) >> 32 from an 8-bit high part and a 32-bit low part
      sq_val = SQ_W'({16'(a_ff[39:32]) * 16'(a_ff[39:32]), 32'b0})
             + SQ_W'(41'(a_ff[39:32]) * 41'(a_ff[31:0]) * 41'd2)
             + SQ_W'(((64'(a_ff[31:0]) * 64'(a_ff[31:0])) >> 32));

      // root step
      rem2  = {rem_ff, sv_ff[2*SI-1 -: 2]};
      trial = (SI+4)'({s_ff, 2'b01});

      m2_full = 64'(s_ff[31:0]) * 64'(LN2_Q32);
      total   = {phi_ff, {SPL_W{1'b0}}} + (LN_W+SPL_W)'(plo_ff);
   end

   assign ring_rd_en  = (state_ff == S_RD);
   assign ret_we      = (state_ff == S_RET) && wrote;
   assign ret_wdata   = ret_val;
   assign ret_rd_en   = (state_ff == S_P2RD);
   assign ret_rd_addr = j_ff[AW-1:0];

   // ---- sequencer --------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      rd_addr_in    = rd_addr_ff;
      k_in          = k_ff;
      m_in          = m_ff;
      x_in          = x_ff;
      cur_zero_in   = cur_zero_ff;
      prev_nz_in    = prev_nz_ff;
      p_in          = p_ff;
      y_in          = y_ff;
      f_in          = f_ff;
      it_in         = it_ff;
      log_prev_in   = log_prev_ff;
      dv_quo_in     = dv_quo_ff;
      dv_rem_in     = dv_rem_ff;
      dv_cnt_in     = dv_cnt_ff;
      neg_in        = neg_ff;
      mean_in       = mean_ff;
      j_in          = j_ff;
      var_in        = var_ff;
      sv_in         = sv_ff;
      s_in          = s_ff;
      rem_in        = rem_ff;
      sq_cnt_in     = sq_cnt_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      sdln_in       = sdln_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      rsp_strobe_in = 1'b0;
      rsp_vol_in    = rsp_vol_ff;
      rsp_def_in    = rsp_def_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_last_candle) begin
               state_in = S_START;
            end
         end
         S_START: begin
            if (n_ff < CW'(2)) begin
               rsp_strobe_in = 1'b1;
               rsp_vol_in    = default_volatility_ff;
               rsp_def_in    = 1'b1;
               state_in      = S_IDLE;
            end else begin
               rd_addr_in = base_ff;
               k_in       = '0;
               m_in       = '0;
               state_in   = S_RD;
            end
         end
         S_RD: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // a zero later close counts as one LSB
            cur_zero_in = (ring_rdata == '0);
            x_in        = (ring_rdata == '0) ? PRICE_W'(1) : ring_rdata;
            p_in        = 6'd47;
            state_in    = S_NORM;
         end
         S_NORM: begin
            if (x_ff[PRICE_W-1]) begin
               y_in     = x_ff[PRICE_W-1 -: 32];
               it_in    = 5'd31;
               state_in = S_SQR;
            end else if (x_ff[PRICE_W-1 -: 8] == '0) begin
               x_in = {x_ff[PRICE_W-9:0], 8'b0};
               p_in = p_ff - 6'd8;
            end else begin
               x_in = {x_ff[PRICE_W-2:0], 1'b0};
               p_in = p_ff - 6'd1;
            end
         end
         S_SQR: begin
            y_in  = y_t[32] ? y_t[32:1] : y_t[31:0];
            f_in  = {f_ff[30:0], y_t[32]};
            it_in = it_ff - 1'b1;
            if (it_ff == '0) begin
               state_in = S_RET;
            end
         end
         S_RET: begin
            m_in        = m_ff + CW'(wrote);
            log_prev_in = log_cur;
            prev_nz_in  = !cur_zero_ff;
            if (k_ff == n_ff - 1'b1) begin
               if (m_in == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_vol_in    = default_volatility_ff;
                  rsp_def_in    = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  dv_quo_in = DW'(sum_mag);
                  dv_rem_in = '0;
                  dv_cnt_in = DCW'(DW - 1);
                  neg_in    = sum_in[SUM_W-1];
                  state_in  = S_MDIV;
               end
            end else begin
               k_in       = k_ff + 1'b1;
               rd_addr_in = rd_addr_nx;
               state_in   = S_RD;
            end
         end
         S_MDIV: begin
            dv_quo_in = dv_quo_nx;
            dv_rem_in = dv_rem_nx;
            dv_cnt_in = dv_cnt_ff - 1'b1;
            if (dv_cnt_ff == '0) begin
               state_in = S_MEAN;
            end
         end
         S_MEAN: begin
            // truncate toward zero
            mean_in  = neg_ff ? -$signed(dv_quo_ff[RET_W-1:0])
                              : $signed(dv_quo_ff[RET_W-1:0]);
            j_in     = '0;
            var_in   = '0;
            state_in = S_P2RD;
         end
         S_P2RD: begin
            state_in = S_P2D;
         end
         S_P2D: begin
            state_in = S_P2SQ;
         end
         S_P2SQ: begin
            var_in = var_ff + DW'(sq_val);
            if (j_ff == m_ff - 1'b1) begin
               dv_quo_in = var_in;
               dv_rem_in = '0;
               dv_cnt_in = DCW'(DW - 1);
               state_in  = S_VDIV;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_P2RD;
            end
         end
         S_VDIV: begin
            dv_quo_in = dv_quo_nx;
            dv_rem_in = dv_rem_nx;
            dv_cnt_in = dv_cnt_ff - 1'b1;
            if (dv_cnt_ff == '0) begin
               sv_in     = (2*SI)'({dv_quo_nx[VQ_W-1:0], 32'b0});
               s_in      = '0;
               rem_in    = '0;
               sq_cnt_in = SQC_W'(SI - 1);
               state_in  = S_SQRT;
            end
         end
         S_SQRT: begin
            sv_in     = {sv_ff[2*SI-3:0], 2'b00};
            sq_cnt_in = sq_cnt_ff - 1'b1;
            if (rem2 >= trial) begin
               rem_in = (SI+2)'(rem2 - trial);
               s_in   = {s_ff[SI-2:0], 1'b1};
            end else begin
               rem_in = rem2[SI+1:0];
               s_in   = {s_ff[SI-2:0], 1'b0};
            end
            if (sq_cnt_ff == '0) begin
               state_in = S_LN;
            end
         end
         S_LN: begin
            m1_in    = 41'(s_ff[SI-1:32]) * 41'(LN2_Q32);
            m2_in    = m2_full[63:32];
            state_in = S_LNADD;
         end
         S_LNADD: begin
            sdln_in  = LN_W'(m1_ff) + LN_W'(m2_ff);
            state_in = S_SCL;
         end
         S_SCL: begin
            plo_in   = (SPL_W+SCALE_W)'(sdln_ff[SPL_W-1:0]) * (SPL_W+SCALE_W)'(annual_scale_ff);
            phi_in   = LN_W'(sdln_ff[LN_W-1:SPL_W]) * LN_W'(annual_scale_ff);
            state_in = S_OUT;
         end
         S_OUT: begin
            // saturate the Q16.16 result
            rsp_strobe_in = 1'b1;
            rsp_vol_in    = (total[LN_W+SPL_W-1:64] != '0) ? '1 : total[63:32];
            rsp_def_in    = 1'b0;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // ---- control registers ------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         head_ff       <= '0;
         fill_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (accept) begin
            head_ff <= head_in;
            fill_ff <= fill_in;
         end
      end
   end

   // ---- payload registers ------------------------------------------------
   always_ff @(posedge clock) begin
      if (accept) begin
         n_ff    <= n_in;
         base_ff <= base_in;
      end
      if (state_ff == S_RET) begin
         sum_ff <= sum_in;
      end else if (state_ff == S_START) begin
         sum_ff <= '0;
      end
      rd_addr_ff  <= rd_addr_in;
      k_ff        <= k_in;
      m_ff        <= m_in;
      x_ff        <= x_in;
      cur_zero_ff <= cur_zero_in;
      prev_nz_ff  <= prev_nz_in;
      p_ff        <= p_in;
      y_ff        <= y_in;
      f_ff        <= f_in;
      it_ff       <= it_in;
      log_prev_ff <= log_prev_in;
      dv_quo_ff   <= dv_quo_in;
      dv_rem_ff   <= dv_rem_in;
      dv_cnt_ff   <= dv_cnt_in;
      neg_ff      <= neg_in;
      mean_ff     <= mean_in;
      j_ff        <= j_in;
      var_ff      <= var_in;
      a_ff        <= (state_ff == S_P2D) ? a_in : a_ff;
      sv_ff       <= sv_in;
      s_ff        <= s_in;
      rem_ff      <= rem_in;
      sq_cnt_ff   <= sq_cnt_in;
      m1_ff       <= m1_in;
      m2_ff       <= m2_in;
      sdln_ff     <= sdln_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      rsp_vol_ff  <= rsp_vol_in;
      rsp_def_ff  <= rsp_def_in;
   end

endmodule : close_to_close_volatility
`default_nettype wire

### rtl/core/ccvol_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ccvol_checker
// Port-level checks of the volatility block, bound to the top level.
// ----------------------------------------------------------------------------
module ccvol_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            start,
   input wire logic                            busy,
   input wire logic [ccvol_pkg::PRICE_W-1:0]   req_close_price,
   input wire logic                            req_last_candle,
   input wire logic                            rsp_strobe,
   input wire logic [ccvol_pkg::VOL_W-1:0]     rsp_volatility,
   input wire logic                            rsp_used_default,
   input wire logic                            csr_wr_en,
   input wire logic [ccvol_pkg::CSR_IDX_W-1:0] csr_index,
   input wire logic [ccvol_pkg::CSR_W-1:0]     csr_wdata
);

   import ccvol_pkg::*;

   logic unused_ok;
   assign unused_ok = ^{req_close_price, rsp_volatility, rsp_used_default,
                        csr_wr_en, csr_index, csr_wdata};

   // result word lasts one cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // a result ends the compute pass
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still busy");

   a_fill_only: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_candle) |=> (!busy && !rsp_strobe))
      else $error("non-final word started a compute pass");

   a_last_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_candle) |=> busy)
      else $error("final word did not start a compute pass");

   a_done_result: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe)
      else $error("compute pass ended without a result word");

endmodule : ccvol_checker

bind close_to_close_volatility ccvol_checker u_ccvol_checker (.*);
`default_nettype wire
